// File: src/jls_pkg.sv
// Shared types and constants of the Jacobi grid solver.
// Used by jls_ctrl, jls_dp and the top level; depends on nothing else.
package jls_pkg;

    localparam int MAX_GRID = 64;
    localparam int IDX_W    = $clog2(MAX_GRID);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int CELLS    = MAX_GRID * MAX_GRID;
    localparam int SIZE_W   = IDX_W + 1;
    localparam int Q_W      = 24;
    localparam int CNT_W    = 20;
    localparam int CFG_W    = 24;
    localparam int REG_W    = 3;
    localparam int STEP_W   = Q_W + 2;
    localparam int SUM_W    = Q_W + 2;
    localparam int DIV_CNT_W = $clog2(Q_W);

    localparam logic [Q_W-1:0] ERR_START = Q_W'(65536);

    localparam logic [REG_W-1:0] REG_GRID_SIZE  = 3'd0;
    localparam logic [REG_W-1:0] REG_TOLERANCE  = 3'd1;
    localparam logic [REG_W-1:0] REG_ITER_LIMIT = 3'd2;
    localparam logic [REG_W-1:0] REG_CORNER_TL  = 3'd3;
    localparam logic [REG_W-1:0] REG_CORNER_TR  = 3'd4;
    localparam logic [REG_W-1:0] REG_CORNER_BL  = 3'd5;
    localparam logic [REG_W-1:0] REG_CORNER_BR  = 3'd6;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic              start_run;
        logic              div_start;
        logic              build_wr;
        logic              cap_old;
        logic              sum_first;
        logic              sum_add;
        logic              sweep_wr;
        logic              sweep_start;
        logic              sweep_end;
        logic              run_done;
        logic              out_read;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic             div_busy;
        logic             sweep_cont;
        logic [IDX_W-1:0] last;
    } t_status;

endpackage

// File: src/jacobi_laplace_grid_solver_unit.sv
// Top level of the Jacobi Laplace grid solver.
// Depends on jls_pkg, jls_ctrl and jls_dp.
//
// Input beats carry a kind on s_axis_tuser: zero builds the grid and runs the
// solver, one reads a cell at the row and column in s_axis_tdata. Each input
// beat gives exactly one output beat with the cell value (zero for a run), the
// sweep count, the final error and the converged flag of the latest run.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write them only while idle, as the block does not enforce it. A read
// goes through an issue and a data state to its output beat. A run does the four
// serial edge divisions, builds the grid and sweeps it, each sweep paced by the
// single grid memory read port (five reads and one write per interior cell).
// One item is in flight at a time; the next beat is taken once the previous
// result has been taken or is taken in the same cycle. A stalled output beat
// holds its data. Reset restores the register defaults and returns to idle;
// the grid memory is not cleared and must not be read before the first run.
module jacobi_laplace_grid_solver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row[5:0], col[11:6], zero fill
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // cell_value, sweeps_done, final_error, converged
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import jls_pkg::*;

    t_cmd    cmd;
    t_status sts;

    jls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_cell_addr (s_axis_tdata[11:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jls_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (m_axis_tdata)
    );

endmodule

// File: src/jls_dp.sv
// Datapath of the Jacobi grid solver: registers, grid banks, edge divider, stencil.
// Depends on jls_pkg; driven by jls_ctrl through t_cmd.
module jls_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [23:0]           i_cfg_data,
    input  jls_pkg::t_cmd         i_cmd,
    output jls_pkg::t_status      o_sts,
    output logic [71:0]           o_result
);
    import jls_pkg::*;

    logic [SIZE_W-1:0] r_grid_size;
    logic [Q_W-1:0]    r_tol, r_tl, r_tr, r_bl, r_br;
    logic [CNT_W-1:0]  r_limit;

    logic [SIZE_W-1:0] r_n, r_run_size, n_n;
    logic [IDX_W-1:0]  r_last;
    logic [Q_W-1:0]    r_err, r_swp_err, r_last_err, r_out_cell, r_old;
    logic [CNT_W-1:0]  r_iter, r_sweeps;
    logic              r_conv, r_cur;

    logic [Q_W-1:0] mem0 [CELLS];
    logic [Q_W-1:0] mem1 [CELLS];
    logic [Q_W-1:0] r_rd0, r_rd1, rd_data;

    logic                   r_div_busy;
    logic [1:0]             r_div_sel;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [Q_W-1:0]         r_dvd;
    logic [IDX_W-1:0]       r_rem;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step [4];
    logic [STEP_W-1:0]      r_acc_top, r_acc_bot, r_acc_lft, r_acc_rgt;
    logic [SUM_W-1:0]       r_sum;

    logic [IDX_W:0]         trial;
    logic [Q_W-1:0]         quot;
    logic [Q_W-1:0]         div_start_v, div_end_v, div_mag;
    logic [Q_W:0]           div_diff;
    logic [1:0]             load_sel;
    logic [IDX_W-1:0]       brow, bcol;
    logic [Q_W-1:0]         build_v;
    logic [SUM_W-1:0]       total;
    logic [Q_W-1:0]         avg, delta;
    logic                   wr0, wr1;

    always_comb begin
        if (r_grid_size < SIZE_W'(3)) begin
            n_n = SIZE_W'(3);
        end else if (r_grid_size > SIZE_W'(MAX_GRID)) begin
            n_n = SIZE_W'(MAX_GRID);
        end else begin
            n_n = r_grid_size;
        end
    end

    assign load_sel = i_cmd.div_start ? 2'd0 : r_div_sel + 2'd1;

    always_comb begin
        unique case (load_sel)
            2'd0: begin div_start_v = r_tl; div_end_v = r_tr; end
            2'd1: begin div_start_v = r_tl; div_end_v = r_bl; end
            2'd2: begin div_start_v = r_bl; div_end_v = r_br; end
            default: begin div_start_v = r_tr; div_end_v = r_br; end
        endcase
        div_diff = {1'b0, div_end_v} - {1'b0, div_start_v};
        div_mag  = div_diff[Q_W] ? Q_W'(-div_diff) : div_diff[Q_W-1:0];
    end

    assign trial = {r_rem, r_dvd[Q_W-1]};
    assign quot  = {r_dvd[Q_W-2:0], trial >= {1'b0, r_last}};

    always_comb begin
        brow = i_cmd.addr[ADDR_W-1:IDX_W];
        bcol = i_cmd.addr[IDX_W-1:0];
        priority if (brow == '0 && bcol == '0) begin
            build_v = r_tl;
        end else if (brow == '0 && bcol == r_last) begin
            build_v = r_tr;
        end else if (brow == r_last && bcol == '0) begin
            build_v = r_bl;
        end else if (brow == r_last && bcol == r_last) begin
            build_v = r_br;
        end else if (brow == '0) begin
            build_v = r_acc_top[Q_W-1:0];
        end else if (brow == r_last) begin
            build_v = r_acc_bot[Q_W-1:0];
        end else if (bcol == '0) begin
            build_v = r_acc_lft[Q_W-1:0];
        end else if (bcol == r_last) begin
            build_v = r_acc_rgt[Q_W-1:0];
        end else begin
            build_v = '0;
        end
    end

    assign rd_data = r_cur ? r_rd1 : r_rd0;
    assign total   = r_sum + SUM_W'(rd_data);
    assign avg     = total[SUM_W-1:2];
    assign delta   = (avg > r_old) ? avg - r_old : r_old - avg;
    assign wr0     = i_cmd.build_wr || (i_cmd.sweep_wr && r_cur);
    assign wr1     = i_cmd.build_wr || (i_cmd.sweep_wr && !r_cur);

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            mem0[i_cmd.addr] <= i_cmd.build_wr ? build_v : avg;
        end
        if (wr1) begin
            mem1[i_cmd.addr] <= i_cmd.build_wr ? build_v : avg;
        end
        r_rd0 <= mem0[i_cmd.addr];
        r_rd1 <= mem1[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SIZE_W'(16);
            r_tol       <= Q_W'(66);
            r_limit     <= CNT_W'(1000);
            r_tl        <= Q_W'(655360);
            r_tr        <= Q_W'(1310720);
            r_bl        <= Q_W'(1310720);
            r_br        <= Q_W'(1966080);
            r_run_size  <= '0;
            r_sweeps    <= '0;
            r_last_err  <= '0;
            r_conv      <= 1'b0;
            r_cur       <= 1'b0;
            r_div_busy  <= 1'b0;
            r_n         <= SIZE_W'(3);
            r_last      <= IDX_W'(2);
            r_err       <= '0;
            r_iter      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GRID_SIZE:  r_grid_size <= i_cfg_data[SIZE_W-1:0];
                    REG_TOLERANCE:  r_tol       <= i_cfg_data[Q_W-1:0];
                    REG_ITER_LIMIT: r_limit     <= i_cfg_data[CNT_W-1:0];
                    REG_CORNER_TL:  r_tl        <= i_cfg_data[Q_W-1:0];
                    REG_CORNER_TR:  r_tr        <= i_cfg_data[Q_W-1:0];
                    REG_CORNER_BL:  r_bl        <= i_cfg_data[Q_W-1:0];
                    REG_CORNER_BR:  r_br        <= i_cfg_data[Q_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start_run) begin
                r_n    <= n_n;
                r_last <= IDX_W'(n_n - SIZE_W'(1));
                r_err  <= ERR_START;
                r_iter <= '0;
                r_cur  <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && r_div_cnt == DIV_CNT_W'(Q_W - 1) && r_div_sel == 2'd3) begin
                r_div_busy <= 1'b0;
            end
            if (i_cmd.sweep_end) begin
                r_err  <= r_swp_err;
                r_iter <= r_iter + CNT_W'(1);
                r_cur  <= !r_cur;
            end
            if (i_cmd.run_done) begin
                r_run_size <= r_n;
                r_sweeps   <= r_iter;
                r_last_err <= r_err;
                r_conv     <= (r_err <= r_tol);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start || (r_div_busy && r_div_cnt == DIV_CNT_W'(Q_W - 1))) begin
            if (!i_cmd.div_start) begin
                r_step[r_div_sel] <= r_neg ? STEP_W'(-{2'b00, quot}) : {2'b00, quot};
            end
            r_div_sel <= load_sel;
            r_div_cnt <= '0;
            r_dvd     <= div_mag;
            r_neg     <= div_diff[Q_W];
            r_rem     <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            r_dvd     <= quot;
            r_rem     <= (trial >= {1'b0, r_last}) ? IDX_W'(trial - {1'b0, r_last})
                                                   : trial[IDX_W-1:0];
        end
        if (i_cmd.div_start) begin
            r_acc_top <= {2'b00, r_tl};
            r_acc_lft <= {2'b00, r_tl};
            r_acc_bot <= {2'b00, r_bl};
            r_acc_rgt <= {2'b00, r_tr};
        end else if (i_cmd.build_wr) begin
            if (brow == '0) begin
                r_acc_top <= r_acc_top + r_step[0];
            end
            if (bcol == '0) begin
                r_acc_lft <= r_acc_lft + r_step[1];
            end
            if (brow == r_last) begin
                r_acc_bot <= r_acc_bot + r_step[2];
            end
            if (bcol == r_last) begin
                r_acc_rgt <= r_acc_rgt + r_step[3];
            end
        end
        if (i_cmd.cap_old) begin
            r_old <= rd_data;
        end
        if (i_cmd.sum_first) begin
            r_sum <= SUM_W'(rd_data);
        end else if (i_cmd.sum_add) begin
            r_sum <= total;
        end
        if (i_cmd.sweep_start) begin
            r_swp_err <= '0;
        end else if (i_cmd.sweep_wr && delta > r_swp_err) begin
            r_swp_err <= delta;
        end
        if (i_cmd.run_done) begin
            r_out_cell <= '0;
        end else if (i_cmd.out_read) begin
            r_out_cell <= (SIZE_W'(brow) < r_run_size && SIZE_W'(bcol) < r_run_size)
                          ? rd_data : '0;
        end
    end

    assign o_sts.div_busy   = r_div_busy;
    assign o_sts.sweep_cont = (r_err > r_tol) && (r_iter < r_limit);
    assign o_sts.last       = r_last;
    assign o_result = {3'b000, r_conv, r_last_err, r_sweeps, r_out_cell};

endmodule

// File: src/jls_ctrl.sv
// Controller of the Jacobi grid solver: sequencer, address counters, beat handshake.
// Depends on jls_pkg; drives jls_dp through t_cmd.
module jls_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [11:0]          i_cell_addr,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  jls_pkg::t_status     i_sts,
    output jls_pkg::t_cmd        o_cmd
);
    import jls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_GO, S_DIV, S_BUILD, S_CHECK, S_SWEEP, S_SWEEP_END,
        S_RUN_END, S_READ_ISSUE, S_READ_DATA
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_row, r_col;
    logic [2:0]       r_phase;
    logic             r_out_valid;
    logic             accept;
    logic [IDX_W-1:0] inner_last;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign inner_last = i_sts.last - IDX_W'(1);

    always_comb begin
        o_cmd = '0;
        o_cmd.start_run = accept && (i_kind == KIND_RUN);
        o_cmd.div_start = (r_state == S_DIV_GO);
        o_cmd.build_wr  = (r_state == S_BUILD);
        o_cmd.addr      = {r_row, r_col};
        if (r_state == S_SWEEP) begin
            unique case (r_phase)
                3'd1: o_cmd.addr = {r_row - IDX_W'(1), r_col};
                3'd2: o_cmd.addr = {r_row + IDX_W'(1), r_col};
                3'd3: o_cmd.addr = {r_row, r_col - IDX_W'(1)};
                3'd4: o_cmd.addr = {r_row, r_col + IDX_W'(1)};
                default: o_cmd.addr = {r_row, r_col};
            endcase
            o_cmd.cap_old   = (r_phase == 3'd1);
            o_cmd.sum_first = (r_phase == 3'd2);
            o_cmd.sum_add   = (r_phase == 3'd3) || (r_phase == 3'd4);
            o_cmd.sweep_wr  = (r_phase == 3'd5);
        end
        o_cmd.sweep_start = (r_state == S_CHECK) && i_sts.sweep_cont;
        o_cmd.sweep_end   = (r_state == S_SWEEP_END);
        o_cmd.run_done    = (r_state == S_RUN_END);
        o_cmd.out_read    = (r_state == S_READ_DATA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_kind == KIND_RUN) begin
                            r_state <= S_DIV_GO;
                        end else begin
                            r_row   <= i_cell_addr[IDX_W-1:0];
                            r_col   <= i_cell_addr[ADDR_W-1:IDX_W];
                            r_state <= S_READ_ISSUE;
                        end
                    end
                end
                S_DIV_GO: r_state <= S_DIV;
                S_DIV: begin
                    if (!i_sts.div_busy) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    if (r_col == i_sts.last) begin
                        r_col <= '0;
                        r_row <= r_row + IDX_W'(1);
                        if (r_row == i_sts.last) begin
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_col <= r_col + IDX_W'(1);
                    end
                end
                S_CHECK: begin
                    r_row   <= IDX_W'(1);
                    r_col   <= IDX_W'(1);
                    r_phase <= '0;
                    r_state <= i_sts.sweep_cont ? S_SWEEP : S_RUN_END;
                end
                S_SWEEP: begin
                    if (r_phase == 3'd5) begin
                        r_phase <= '0;
                        if (r_col == inner_last) begin
                            r_col <= IDX_W'(1);
                            r_row <= r_row + IDX_W'(1);
                            if (r_row == inner_last) begin
                                r_state <= S_SWEEP_END;
                            end
                        end else begin
                            r_col <= r_col + IDX_W'(1);
                        end
                    end else begin
                        r_phase <= r_phase + 3'd1;
                    end
                end
                S_SWEEP_END: r_state <= S_CHECK;
                S_RUN_END: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_READ_ISSUE: r_state <= S_READ_DATA;
                S_READ_DATA: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_run_starts_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_RUN) |=> (r_state == S_DIV_GO))
        else $error("run beat did not start the edge divider");

    a_build_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.build_wr |-> (r_row <= i_sts.last && r_col <= i_sts.last))
        else $error("build write outside the grid");

    a_sweep_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_wr |-> (r_row >= IDX_W'(1) && r_row < i_sts.last &&
                            r_col >= IDX_W'(1) && r_col < i_sts.last))
        else $error("sweep wrote a boundary cell");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN_END || r_state == S_READ_DATA) |-> (!r_out_valid || i_out_ready))
        else $error("result would overwrite a pending beat");

endmodule

// File: sim/jls_result_checker.sv
// Result checker for the Jacobi Laplace grid solver testbench.
// Watches the config port and both streams, predicts every result beat and
// compares it; depends on jls_pkg only.
module jls_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import jls_pkg::*;

    typedef struct packed {
        logic [Q_W-1:0]   cell_val;
        logic [CNT_W-1:0] sweeps;
        logic [Q_W-1:0]   err;
        logic             conv;
    } t_solver_beat;

    t_solver_beat beat_q[$];

    logic [SIZE_W-1:0] size_reg;
    logic [Q_W-1:0]    tol_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [Q_W-1:0]    tl_reg, tr_reg, bl_reg, br_reg;

    logic [Q_W-1:0]    grid_cur [CELLS];
    logic [Q_W-1:0]    grid_nxt [CELLS];
    logic [CNT_W-1:0]  last_sweeps;
    logic [Q_W-1:0]    last_err;
    logic              last_conv;
    int                last_n;

    function automatic logic [Q_W-1:0] lerp(logic [Q_W-1:0] a, logic [Q_W-1:0] b,
                                             int span, int i);
        longint diff, stp, v;
        diff = longint'(b) - longint'(a);
        stp  = diff / longint'(span);
        v    = stp * longint'(i) + longint'(a);
        if (v < 0) v = 0;
        if (v > longint'(24'hFFFFFF)) v = longint'(24'hFFFFFF);
        return v[Q_W-1:0];
    endfunction

    task automatic build_grid(int n);
        int last;
        last = n - 1;
        for (int k = 0; k < CELLS; k++) grid_cur[k] = '0;
        grid_cur[0]                    = tl_reg;
        grid_cur[last]                 = tr_reg;
        grid_cur[last * MAX_GRID]      = bl_reg;
        grid_cur[last * MAX_GRID + last] = br_reg;
        for (int i = 1; i < last; i++) begin
            grid_cur[i]                   = lerp(tl_reg, tr_reg, last, i);
            grid_cur[i * MAX_GRID]        = lerp(tl_reg, bl_reg, last, i);
            grid_cur[last * MAX_GRID + i] = lerp(bl_reg, br_reg, last, i);
            grid_cur[i * MAX_GRID + last] = lerp(tr_reg, br_reg, last, i);
        end
        grid_nxt = grid_cur;
    endtask

    task automatic jacobi_sweep(int n, output logic [31:0] err);
        int k;
        logic [31:0] s, v, old, d;
        err = 0;
        for (int r = 1; r + 1 < n; r++) begin
            for (int c = 1; c + 1 < n; c++) begin
                k   = r * MAX_GRID + c;
                s   = 32'(grid_cur[k-1]) + 32'(grid_cur[k+1])
                    + 32'(grid_cur[k-MAX_GRID]) + 32'(grid_cur[k+MAX_GRID]);
                v   = s >> 2;
                old = 32'(grid_cur[k]);
                d   = (v > old) ? v - old : old - v;
                if (v > 32'hFFFFFF) v = 32'hFFFFFF;
                grid_nxt[k] = v[Q_W-1:0];
                if (d > err) err = d;
            end
        end
        for (int r = 1; r + 1 < n; r++)
            for (int c = 1; c + 1 < n; c++)
                grid_cur[r * MAX_GRID + c] = grid_nxt[r * MAX_GRID + c];
        err &= 32'hFFFFFF;
    endtask

    task automatic solve_run();
        int n;
        logic [31:0] err;
        logic [31:0] iters;
        n = size_reg;
        if (n < 3) n = 3;
        if (n > MAX_GRID) n = MAX_GRID;
        build_grid(n);
        err   = 32'(ERR_START);
        iters = 0;
        while (err > 32'(tol_reg) && iters < 32'(limit_reg)) begin
            jacobi_sweep(n, err);
            iters++;
        end
        last_sweeps = iters[CNT_W-1:0];
        last_err    = err[Q_W-1:0];
        last_conv   = (err <= 32'(tol_reg));
        last_n      = n;
    endtask

    always @(posedge i_clk) begin
        t_solver_beat want, got;
        int row, col;
        if (!i_rst_n) begin
            size_reg    <= 7'd16;
            tol_reg     <= 24'd66;
            limit_reg   <= 20'd1000;
            tl_reg      <= 24'd655360;
            tr_reg      <= 24'd1310720;
            bl_reg      <= 24'd1310720;
            br_reg      <= 24'd1966080;
            last_sweeps <= '0;
            last_err    <= '0;
            last_conv   <= 1'b0;
            last_n      <= 0;
            beat_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_SIZE:  size_reg  <= i_cfg_data[SIZE_W-1:0];
                    REG_TOLERANCE:  tol_reg   <= i_cfg_data;
                    REG_ITER_LIMIT: limit_reg <= i_cfg_data[CNT_W-1:0];
                    REG_CORNER_TL:  tl_reg    <= i_cfg_data;
                    REG_CORNER_TR:  tr_reg    <= i_cfg_data;
                    REG_CORNER_BL:  bl_reg    <= i_cfg_data;
                    REG_CORNER_BR:  br_reg    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want.cell_val = '0;
                if (s_axis_tuser == KIND_RUN) begin
                    solve_run();
                end else begin
                    row = s_axis_tdata[5:0];
                    col = s_axis_tdata[11:6];
                    if (row < last_n && col < last_n)
                        want.cell_val = grid_cur[row * MAX_GRID + col];
                end
                want.sweeps = last_sweeps;
                want.err    = last_err;
                want.conv   = last_conv;
                beat_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.cell_val = m_axis_tdata[23:0];
                got.sweeps   = m_axis_tdata[43:24];
                got.err      = m_axis_tdata[67:44];
                got.conv     = m_axis_tdata[68];
                if (beat_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = beat_q.pop_front();
                    if (got.cell_val !== want.cell_val || got.sweeps !== want.sweeps ||
                        got.err !== want.err || got.conv !== want.conv) begin
                        if (o_fail_count < 10)
                            $display({"%0t: mismatch cell %h/%h sweeps %0d/%0d ",
                                      "error %h/%h converged %b/%b (expected/actual)"},
                                     $realtime, want.cell_val, got.cell_val, want.sweeps,
                                     got.sweeps, want.err, got.err, want.conv, got.conv);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= beat_q.size();
        end
    end

endmodule

// File: sim/jacobi_laplace_grid_solver_unit_tb.sv
// Testbench top for the Jacobi Laplace grid solver: clock, reset, register
// setup, command beats and output stalls. Depends on jls_pkg, the block and
// jls_result_checker, which does all prediction and comparison.
module jacobi_laplace_grid_solver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jls_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;
    int          fail_count;
    int          pending;
    bit          calm;
    int          cmd_count;
    int          eff_size;

    jacobi_laplace_grid_solver_unit dut (.*);

    jls_result_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("FAIL jacobi_laplace_grid_solver_unit");
        $finish;
    end

    initial begin
        int stall_left, go_left;
        m_axis_tready = 1'b0;
        stall_left = 0;
        go_left = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (go_left > 0) begin
                m_axis_tready = 1'b1;
                go_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_axis_tready = 1'b1;
                go_left = $urandom_range(0, 12);
            end
        end
    end

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
    endtask

    task automatic setup(int size, logic [23:0] tol, logic [19:0] lim, logic [23:0] tl,
                         logic [23:0] tr, logic [23:0] bl, logic [23:0] br);
        wait_idle();
        write_reg(REG_GRID_SIZE, 24'(size));
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_ITER_LIMIT, 24'(lim));
        write_reg(REG_CORNER_TL, tl);
        write_reg(REG_CORNER_TR, tr);
        write_reg(REG_CORNER_BL, bl);
        write_reg(REG_CORNER_BR, br);
        if ($urandom_range(0, 3) == 0) write_reg(3'd7, 24'($urandom));
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        eff_size = size < 3 ? 3 : (size > MAX_GRID ? MAX_GRID : size);
    endtask

    task automatic send_cmd(logic kind, int row, int col);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {4'b0, 6'(col), 6'(row)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cmd_count++;
    endtask

    task automatic read_any();
        if ($urandom_range(0, 4) == 0)
            send_cmd(KIND_READ, $urandom_range(0, 63), $urandom_range(0, 63));
        else
            send_cmd(KIND_READ, $urandom_range(0, eff_size - 1),
                     $urandom_range(0, eff_size - 1));
    endtask

    initial begin
        int size, lim, reads;
        logic [23:0] tol;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_RUN;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        cmd_count = 0;
        eff_size = 16;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        setup(3, 24'd0, 20'hFFFFF, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h0);
        send_cmd(KIND_RUN, 0, 0);
        send_cmd(KIND_READ, 0, 0);
        send_cmd(KIND_READ, 1, 1);
        send_cmd(KIND_READ, 2, 2);
        send_cmd(KIND_READ, 0, 2);
        send_cmd(KIND_READ, 63, 63);
        send_cmd(KIND_READ, 2, 3);
        setup(0, 24'hFFFFFF, 20'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_cmd(KIND_RUN, 63, 63);
        send_cmd(KIND_READ, 1, 1);
        send_cmd(KIND_READ, 0, 1);
        setup(127, 24'd65536, 20'd3, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF);
        send_cmd(KIND_RUN, 0, 0);
        send_cmd(KIND_READ, 63, 63);
        send_cmd(KIND_READ, 63, 0);
        send_cmd(KIND_READ, 32, 63);
        setup(64, 24'd0, 20'd2, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        send_cmd(KIND_RUN, 0, 0);
        send_cmd(KIND_READ, 1, 1);
        send_cmd(KIND_READ, 62, 62);
        setup(12, 24'd0, 20'd7, 24'd100, 24'hABCDEF, 24'h123456, 24'd5);
        send_cmd(KIND_RUN, 0, 0);
        send_cmd(KIND_READ, 5, 6);
        send_cmd(KIND_RUN, 0, 0);

        while (cmd_count < 132) begin
            calm = (cmd_count > 112);
            case ($urandom_range(0, 9))
                0:       size = $urandom_range(0, 2);
                1:       size = $urandom_range(11, 127);
                default: size = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 3))
                0:       tol = '0;
                1:       tol = 24'($urandom);
                default: tol = 24'($urandom_range(0, 4000));
            endcase
            lim = (size > 10) ? $urandom_range(0, 2) : $urandom_range(0, 30);
            setup(size, tol, 20'(lim), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom));
            send_cmd(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
            reads = $urandom_range(3, 10);
            repeat (reads) begin
                if ($urandom_range(0, 11) == 0 && size <= 10)
                    send_cmd(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
                else
                    read_any();
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS jacobi_laplace_grid_solver_unit");
        else
            $display("FAIL jacobi_laplace_grid_solver_unit");
        $finish;
    end

endmodule
